### hdl/two_level_page_table_engine_core_assert.svh
// Assertion macros for the page table engine RTL.
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_CORE_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk_i and held off during reset.
`define TLPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and held off during reset.
`define TLPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tlpt_pkg.sv
// Shared types, constants and helpers of the two-level page table engine.
`default_nettype none

package tlpt_pkg;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  localparam int DIR_ENTRIES   = 1024;
  localparam int DIR_AW        = 10;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TBL_IW        = 10;
  localparam int PAGE_W        = 20;
  localparam int OFS_W         = 12;
  localparam int CNT_W         = 11;
  localparam logic [CNT_W-1:0] MAX_RUN = 11'd1024;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 56;

  // Width of a pool table number.
  function automatic int tbl_idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  // One second-level table entry.
  typedef struct packed {
    logic              present;
    logic              user;
    logic              rw;
    logic [PAGE_W-1:0] page;
  } tbl_entry_t;

  // Directory memory port control.
  typedef struct packed {
    logic              we;
    logic [DIR_AW-1:0] waddr;
    logic [DIR_AW-1:0] raddr;
  } dir_req_t;

  // Table memory write control.
  typedef struct packed {
    logic       we;
    tbl_entry_t wdata;
  } tbl_wr_t;

  // One accepted input transaction.
  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       virt_address;
    logic [PAGE_W-1:0] virt_page;
    logic [PAGE_W-1:0] phys_page;
    logic [CNT_W-1:0]  page_count;
    logic              user_access;
    logic              writable;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0]      phys_address;
    logic             fault;
    logic [CNT_W-1:0] mapped_count;
    logic [CNT_W-1:0] skipped_count;
    logic             pool_exhausted;
  } res_t;

endpackage

`default_nettype wire

### hdl/tlpt_dir_mem.sv
// Page directory memory: 1024 entries of {present, table number}, registered read.
`default_nettype none

module tlpt_dir_mem
  import tlpt_pkg::*;
#(
  parameter int EntryW = 5
) (
  input  wire logic              clk_i,
  input  wire dir_req_t          req_i,
  input  wire logic [EntryW-1:0] wdata_i,
  output logic      [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [DIR_ENTRIES];
  logic [EntryW-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= wdata_i;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/tlpt_tbl_mem.sv
// Second-level table pool memory, registered read.
`default_nettype none

module tlpt_tbl_mem
  import tlpt_pkg::*;
#(
  parameter int POOL_TABLES = 16
) (
  input  wire logic                                  clk_i,
  input  wire tbl_wr_t                               wr_i,
  input  wire logic [tbl_idx_w(POOL_TABLES)+TBL_IW-1:0] waddr_i,
  input  wire logic [tbl_idx_w(POOL_TABLES)+TBL_IW-1:0] raddr_i,
  output tbl_entry_t                                 rdata_o
);

  localparam int Depth = POOL_TABLES * TABLE_ENTRIES;

  tbl_entry_t mem_q [Depth];
  tbl_entry_t rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[waddr_i] <= wr_i.wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/tlpt_ctrl.sv
// Sequencer that walks, fills and clears the directory and table memories.
`default_nettype none
`include "two_level_page_table_engine_core_assert.svh"

module tlpt_ctrl
  import tlpt_pkg::*;
#(
  parameter int POOL_TABLES = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  paging_en_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire item_t                                 in_item_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output res_t                                       out_res_o,
  output dir_req_t                                   dir_req_o,
  output logic [tbl_idx_w(POOL_TABLES):0]            dir_wdata_o,
  input  wire logic [tbl_idx_w(POOL_TABLES):0]       dir_rdata_i,
  output tbl_wr_t                                    tbl_wr_o,
  output logic [tbl_idx_w(POOL_TABLES)+TBL_IW-1:0]   tbl_waddr_o,
  output logic [tbl_idx_w(POOL_TABLES)+TBL_IW-1:0]   tbl_raddr_o,
  input  wire tbl_entry_t                            tbl_rdata_i
);

  localparam int TW = tbl_idx_w(POOL_TABLES);
  localparam int UW = $clog2(POOL_TABLES + 1);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_T_DRD = 4'd2;
  localparam logic [3:0] ST_T_DIR = 4'd3;
  localparam logic [3:0] ST_T_TRD = 4'd4;
  localparam logic [3:0] ST_T_TBL = 4'd5;
  localparam logic [3:0] ST_M_DRD = 4'd6;
  localparam logic [3:0] ST_M_DIR = 4'd7;
  localparam logic [3:0] ST_M_CLR = 4'd8;
  localparam logic [3:0] ST_M_TRD = 4'd9;
  localparam logic [3:0] ST_M_TBL = 4'd10;
  localparam logic [3:0] ST_CLR   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]        state_q, state_d;
  logic [DIR_AW-1:0] sweep_q, sweep_d;
  logic [UW-1:0]     used_q, used_d;
  logic [TW-1:0]     cur_table_q, cur_table_d;
  logic [CNT_W-1:0]  remain_q, remain_d;
  logic [PAGE_W-1:0] vpage_q, vpage_d;
  logic [PAGE_W-1:0] ppage_q, ppage_d;
  item_t             item_q, item_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  run_len;
  logic [TBL_IW-1:0] tidx;
  logic              dir_present;

  // Runs longer than one directory span are cut to 1024 pages.
  assign run_len = (in_item_i.page_count > MAX_RUN) ? MAX_RUN : in_item_i.page_count;

  // Table index of the current walk: from the address for translate, the page for map.
  assign tidx = (item_q.op == OP_TRANSLATE) ? item_q.virt_address[21:12] : vpage_q[TBL_IW-1:0];

  assign dir_present = dir_rdata_i[TW];

  // Next-state and memory control.
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    used_d      = used_q;
    cur_table_d = cur_table_q;
    remain_d    = remain_q;
    vpage_d     = vpage_q;
    ppage_d     = ppage_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    dir_req_o       = '0;
    dir_req_o.raddr = (item_q.op == OP_TRANSLATE) ? item_q.virt_address[31:22]
                                                  : vpage_q[PAGE_W-1:TBL_IW];
    dir_wdata_o     = '0;
    tbl_wr_o        = '0;
    tbl_waddr_o     = {cur_table_q, vpage_q[TBL_IW-1:0]};
    tbl_raddr_o     = {cur_table_q, tidx};
    in_ready_o      = (state_q == ST_IDLE);

    // The result register empties when the sink takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q) inside
      ST_INIT, ST_CLR: begin
        // Sweep the directory, marking every slot absent.
        dir_req_o.we    = 1'b1;
        dir_req_o.waddr = sweep_q;
        sweep_d         = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = (state_q == ST_CLR) ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          vpage_d = in_item_i.virt_page;
          ppage_d = in_item_i.phys_page;
          res_d   = '0;
          case (in_item_i.op)
            OP_TRANSLATE: begin
              if (!paging_en_i) begin
                res_d.phys_address = in_item_i.virt_address;
                state_d            = ST_DONE;
              end else begin
                state_d = ST_T_DRD;
              end
            end
            OP_MAP: begin
              remain_d = run_len;
              state_d  = (run_len == '0) ? ST_DONE : ST_M_DRD;
            end
            OP_CLEAR: begin
              used_d  = '0;
              sweep_d = '0;
              state_d = ST_CLR;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_T_DRD: begin
        state_d = ST_T_DIR;
      end
      ST_T_DIR: begin
        if (dir_present) begin
          cur_table_d = dir_rdata_i[TW-1:0];
          state_d     = ST_T_TRD;
        end else begin
          res_d.fault = 1'b1;
          state_d     = ST_DONE;
        end
      end
      ST_T_TRD: begin
        state_d = ST_T_TBL;
      end
      ST_T_TBL: begin
        if (tbl_rdata_i.present) begin
          res_d.phys_address = {tbl_rdata_i.page, item_q.virt_address[OFS_W-1:0]};
        end else begin
          res_d.fault = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_M_DRD: begin
        state_d = ST_M_DIR;
      end
      ST_M_DIR: begin
        // Use the existing table, take a fresh one, or stop on an empty pool.
        if (dir_present) begin
          cur_table_d = dir_rdata_i[TW-1:0];
          state_d     = ST_M_TRD;
        end else if (used_q >= UW'(POOL_TABLES)) begin
          res_d.pool_exhausted = 1'b1;
          state_d              = ST_DONE;
        end else begin
          cur_table_d = used_q[TW-1:0];
          sweep_d     = '0;
          state_d     = ST_M_CLR;
        end
      end
      ST_M_CLR: begin
        // Zero the new table, then link it into the directory.
        tbl_wr_o.we = 1'b1;
        tbl_waddr_o = {cur_table_q, sweep_q};
        sweep_d     = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          dir_req_o.we    = 1'b1;
          dir_req_o.waddr = vpage_q[PAGE_W-1:TBL_IW];
          dir_wdata_o     = {1'b1, cur_table_q};
          used_d          = used_q + 1'b1;
          state_d         = ST_M_TRD;
        end
      end
      ST_M_TRD: begin
        state_d = ST_M_TBL;
      end
      ST_M_TBL: begin
        // Skip a page already present, otherwise install it.
        if (tbl_rdata_i.present) begin
          res_d.skipped_count = res_q.skipped_count + 1'b1;
        end else begin
          tbl_wr_o.we            = 1'b1;
          tbl_wr_o.wdata.present = 1'b1;
          tbl_wr_o.wdata.user    = item_q.user_access;
          tbl_wr_o.wdata.rw      = item_q.writable;
          tbl_wr_o.wdata.page    = ppage_q;
          res_d.mapped_count     = res_q.mapped_count + 1'b1;
        end
        vpage_d  = vpage_q + 1'b1;
        ppage_d  = ppage_q + 1'b1;
        remain_d = remain_q - 1'b1;
        state_d  = (remain_q == CNT_W'(1)) ? ST_DONE : ST_M_DRD;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      used_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      used_q      <= used_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_table_q <= cur_table_d;
    vpage_q     <= vpage_d;
    ppage_q     <= ppage_d;
    item_q      <= item_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Checks on pool bookkeeping and results.
  `TLPT_ASSERT_IMP(a_pool_bound, 1'b1, used_q <= UW'(POOL_TABLES), "pool count beyond pool size")
  `TLPT_ASSERT_IMP(a_clr_next_table, state_q == ST_M_CLR, UW'(cur_table_q) == used_q, "cleared table is not the next free one")
  `TLPT_ASSERT_NXT(a_alloc_step, state_q == ST_M_CLR && sweep_q == '1, used_q == $past(used_q) + 1'b1, "table taken without pool count step")
  `TLPT_ASSERT_IMP(a_fault_addr_zero, out_valid_q && out_q.fault, out_q.phys_address == '0, "fault result carries an address")

endmodule

`default_nettype wire

### hdl/two_level_page_table_engine_core.sv
// Top level of the two-level page table engine: ports, configuration and memories.
//
// The engine holds a 1024-entry page directory and a pool of POOL_TABLES second-level
// tables of 1024 entries in two synchronous memories with registered reads, and
// handles one transaction at a time. After reset it sweeps every directory slot
// before it accepts its first transaction; configuration writes are taken
// throughout. A translate makes two dependent memory reads, directory then table,
// or passes the address through with paging off. A map reads the directory and
// the table for each page, and zeroes every fresh table it takes from the pool one
// entry per cycle through the table memory's single write port. A clear sweeps the
// whole directory. Unused op code 3 returns an all-zero result. A finished result
// waits in an output register, so the next transaction may be accepted before the
// previous result is taken.
`default_nettype none

module two_level_page_table_engine_core
  import tlpt_pkg::*;
#(
  parameter int POOL_TABLES = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_wdata_i,    // paging_enabled
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // virt_address, virt_page, phys_page, page_count, user_access, writable, zero fill
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  wire logic [1:0]             s_axis_tuser,   // op
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // phys_address, fault, mapped_count, skipped_count, pool_exhausted
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int TW = tbl_idx_w(POOL_TABLES);

  logic                 paging_q;
  item_t                in_item;
  res_t                 out_res;
  dir_req_t             dir_req;
  logic [TW:0]          dir_wdata;
  logic [TW:0]          dir_rdata;
  tbl_wr_t              tbl_wr;
  logic [TW+TBL_IW-1:0] tbl_waddr;
  logic [TW+TBL_IW-1:0] tbl_raddr;
  tbl_entry_t           tbl_rdata;

  // Paging enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q <= 1'b0;
    end else if (cfg_we_i) begin
      paging_q <= cfg_wdata_i;
    end
  end

  // Unpack the input transaction.
  assign in_item.op           = s_axis_tuser;
  assign in_item.virt_address = s_axis_tdata[31:0];
  assign in_item.virt_page    = s_axis_tdata[51:32];
  assign in_item.phys_page    = s_axis_tdata[71:52];
  assign in_item.page_count   = s_axis_tdata[82:72];
  assign in_item.user_access  = s_axis_tdata[83];
  assign in_item.writable     = s_axis_tdata[84];

  tlpt_ctrl #(
    .POOL_TABLES(POOL_TABLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .paging_en_i (paging_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res),
    .dir_req_o   (dir_req),
    .dir_wdata_o (dir_wdata),
    .dir_rdata_i (dir_rdata),
    .tbl_wr_o    (tbl_wr),
    .tbl_waddr_o (tbl_waddr),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata)
  );

  tlpt_dir_mem #(
    .EntryW(TW + 1)
  ) u_dir_mem (
    .clk_i   (clk_i),
    .req_i   (dir_req),
    .wdata_i (dir_wdata),
    .rdata_o (dir_rdata)
  );

  tlpt_tbl_mem #(
    .POOL_TABLES(POOL_TABLES)
  ) u_tbl_mem (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .waddr_i (tbl_waddr),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // Pack the result transaction, first field in the lowest bits.
  assign m_axis_tdata = {out_res.pool_exhausted, out_res.skipped_count,
                         out_res.mapped_count, out_res.fault, out_res.phys_address};

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the two-level page table engine core.
`timescale 1ns / 100ps

module tb;
  import tlpt_pkg::*;

  localparam int POOL_TABLES = 16;
  localparam int TBL_W = $clog2(POOL_TABLES);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int LONG_HOLD = 600;
  localparam int MAX_PRINTED = 40;
  localparam int LIVE_DEPTH = 64;
  localparam int HOT_SLOTS = 24;
  localparam int PHASES = 5;
  localparam logic [PHASES-1:0] PHASE_PAGING = 5'b11011;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_e;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_wdata_i = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = OP_TRANSLATE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  two_level_page_table_engine_core #(
    .POOL_TABLES(POOL_TABLES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock, 8 ns period.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Shadow copy of the engine state, advanced once per accepted transaction.
  logic              dir_present    [DIR_ENTRIES];
  logic [TBL_W-1:0]  dir_slot_table [DIR_ENTRIES];
  tbl_entry_t        pool_mem       [POOL_TABLES*TABLE_ENTRIES];
  int unsigned       tables_taken;
  logic              paging_on;

  res_t              awaited_results [$];
  logic [PAGE_W-1:0] live_pages [$];
  logic [DIR_AW-1:0] hot_slot [HOT_SLOTS];

  int   error_count = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic gaps_off = 1'b0;

  int        hold_asked = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  rx_style_e rx_style = RX_STEADY;
  int        rx_style_left = 0;
  int        rx_phase = 0;
  logic      rx_pick;

  res_t want;
  res_t got;

  // Computes the result of one transaction and applies its side effects to the shadow state.
  function automatic res_t predict_walk(input item_t req);
    res_t              r;
    tbl_entry_t        e;
    logic [PAGE_W-1:0] v;
    logic [DIR_AW-1:0] d;
    int                run;
    int                base;
    r = '0;
    case (req.op)
      OP_TRANSLATE: begin
        if (!paging_on) begin
          r.phys_address = req.virt_address;
        end else begin
          d = req.virt_address[31:22];
          e = '0;
          if (dir_present[d]) begin
            base = int'(dir_slot_table[d]) * TABLE_ENTRIES + int'(req.virt_address[21:12]);
            e = pool_mem[base];
          end
          if (e.present) r.phys_address = {e.page, req.virt_address[OFS_W-1:0]};
          else r.fault = 1'b1;
        end
      end
      OP_MAP: begin
        run = (req.page_count > MAX_RUN) ? int'(MAX_RUN) : int'(req.page_count);
        for (int i = 0; i < run; i++) begin
          v = req.virt_page + PAGE_W'(i);
          d = v[PAGE_W-1:TBL_IW];
          // A missing directory slot takes the next pool table, zeroed.
          if (!dir_present[d]) begin
            if (tables_taken >= POOL_TABLES) begin
              r.pool_exhausted = 1'b1;
              break;
            end
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
              pool_mem[tables_taken * TABLE_ENTRIES + j] = '0;
            end
            dir_slot_table[d] = TBL_W'(tables_taken);
            dir_present[d] = 1'b1;
            tables_taken++;
          end
          base = int'(dir_slot_table[d]) * TABLE_ENTRIES + int'(v[TBL_IW-1:0]);
          if (pool_mem[base].present) begin
            r.skipped_count = r.skipped_count + 1'b1;
          end else begin
            pool_mem[base] = '{present: 1'b1, user: req.user_access, rw: req.writable,
                               page: req.phys_page + PAGE_W'(i)};
            r.mapped_count = r.mapped_count + 1'b1;
            // Remember recent mappings so that later translations can hit them.
            if (live_pages.size() >= LIVE_DEPTH) void'(live_pages.pop_front());
            live_pages.push_back(v);
          end
        end
      end
      OP_CLEAR: begin
        foreach (dir_present[k]) dir_present[k] = 1'b0;
        tables_taken = 0;
        live_pages.delete();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Counts a failure and prints it while the log is still short.
  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR at result %0d: %s", results_seen, what);
  endtask

  // Offers one transaction, with bursts and random gaps, and records its expected result.
  task automatic offer_request(input item_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (gaps_off || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, req.writable, req.user_access, req.page_count,
                      req.phys_page, req.virt_page, req.virt_address};
    s_axis_tuser  <= req.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.push_back(predict_walk(req));
  endtask

  function automatic item_t blank_request(input logic [1:0] op);
    item_t r;
    r = '0;
    r.op = op;
    return r;
  endfunction

  task automatic translate(input logic [31:0] addr);
    item_t r;
    r = blank_request(OP_TRANSLATE);
    r.virt_address = addr;
    offer_request(r);
  endtask

  task automatic map_run(input logic [PAGE_W-1:0] vp, input logic [PAGE_W-1:0] pp,
                         input logic [CNT_W-1:0] cnt, input logic user, input logic rw);
    item_t r;
    r = blank_request(OP_MAP);
    r.virt_page   = vp;
    r.phys_page   = pp;
    r.page_count  = cnt;
    r.user_access = user;
    r.writable    = rw;
    offer_request(r);
  endtask

  // Stops offering and waits until the engine has delivered every result.
  task automatic settle_engine();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_paging(input logic enable);
    settle_engine();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    paging_on = enable;
  endtask

  // Mostly well-formed traffic around a few hot directory slots, with some noise.
  function automatic item_t random_request();
    item_t             r;
    int                pick;
    int                c;
    logic [PAGE_W-1:0] page;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      r.op = 2'($urandom_range(0, 3));
      if (r.op == OP_CLEAR && $urandom_range(0, 1) == 1) r.op = OP_UNUSED;
      r.virt_address = $urandom;
      r.virt_page    = PAGE_W'($urandom);
      r.phys_page    = PAGE_W'($urandom);
      r.page_count   = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom)
                                                   : CNT_W'($urandom_range(0, 15));
      r.user_access  = 1'($urandom);
      r.writable     = 1'($urandom);
    end else if (pick < 50) begin
      r.op = OP_TRANSLATE;
      if (live_pages.size() > 0 && $urandom_range(0, 3) != 0) begin
        page = live_pages[$urandom_range(0, live_pages.size() - 1)];
        if ($urandom_range(0, 3) == 0) page = page + 1'b1;
        r.virt_address = {page, OFS_W'($urandom)};
      end else begin
        r.virt_address = $urandom;
      end
    end else if (pick < 94) begin
      r.op = OP_MAP;
      c = $urandom_range(0, 9);
      if (c < 6) begin
        r.virt_page = {hot_slot[$urandom_range(0, HOT_SLOTS - 1)],
                       ($urandom_range(0, 1) == 1) ? TBL_IW'($urandom)
                                                   : TBL_IW'($urandom_range(0, 31))};
      end else if (c < 8 && live_pages.size() > 0) begin
        r.virt_page = live_pages[$urandom_range(0, live_pages.size() - 1)]
                      - PAGE_W'($urandom_range(0, 3));
      end else begin
        r.virt_page = PAGE_W'($urandom);
      end
      r.phys_page = PAGE_W'($urandom);
      c = $urandom_range(0, 99);
      if (c < 80) r.page_count = CNT_W'($urandom_range(0, 12));
      else if (c < 96) r.page_count = CNT_W'($urandom_range(13, 100));
      else r.page_count = CNT_W'($urandom);
      r.user_access = 1'($urandom);
      r.writable    = 1'($urandom);
    end else if (pick < 97) begin
      r.op = OP_CLEAR;
    end else begin
      r.op = OP_UNUSED;
      r.virt_address = $urandom;
      r.page_count   = CNT_W'($urandom);
    end
    return r;
  endfunction

  // With paging off a translation passes through, while a map still builds tables.
  task automatic test_paging_off();
    item_t r;
    set_paging(1'b0);
    translate(32'h0000_0000);
    translate(32'hFFFF_FFFF);
    translate(32'h5A5A_A5A5);
    r = '1;
    r.op = OP_UNUSED;
    offer_request(r);
    map_run(20'h00400, 20'h12345, 11'd2, 1'b1, 1'b0);
    translate(32'h0040_0123);
  endtask

  // Hits in both levels, a miss in the second level and a miss in the directory.
  task automatic test_translate_walk();
    set_paging(1'b1);
    translate(32'h0040_0123);
    translate(32'h0040_1FFF);
    translate(32'h0040_2000);
    translate(32'hFFC0_0FFF);
  endtask

  // Runs that wrap the page space, an empty run, an overlong run and an overlapping run.
  task automatic test_map_runs();
    map_run(20'hFFFFE, 20'hFFFFF, 11'd4, 1'b1, 1'b1);
    translate(32'hFFFF_FABC);
    translate(32'h0000_1FFF);
    map_run(20'h00400, 20'h00000, 11'd0, 1'b0, 1'b0);
    map_run(20'h003FF, 20'h0AAAA, 11'd2047, 1'b0, 1'b1);
    translate(32'h007F_E800);
    map_run(20'h00400, 20'h55555, 11'd4, 1'b1, 1'b0);
  endtask

  // After a clear every earlier mapping faults.
  task automatic test_clear_directory();
    offer_request(blank_request(OP_CLEAR));
    translate(32'h0040_0123);
    translate(32'hFFFF_FABC);
    offer_request(blank_request(OP_UNUSED));
  endtask

  // Fills the pool through distinct directory slots until a map runs out of tables.
  task automatic test_pool_exhaustion();
    item_t             r;
    logic [DIR_AW-1:0] slot;
    offer_request(blank_request(OP_CLEAR));
    for (int k = 0; k < 20; k++) begin
      slot = DIR_AW'(k * 37 + 5);
      r = blank_request(OP_MAP);
      r.virt_page   = {slot, TBL_IW'($urandom)};
      r.phys_page   = PAGE_W'($urandom);
      r.page_count  = CNT_W'($urandom_range(1, 6));
      r.user_access = 1'($urandom);
      r.writable    = 1'($urandom);
      offer_request(r);
      translate({r.virt_page, OFS_W'($urandom)});
    end
    // This run starts in a slot that has a table and runs into one that has none.
    map_run({DIR_AW'(5), TBL_IW'(10'h3FE)}, PAGE_W'($urandom), 11'd4, 1'b0, 1'b1);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    gaps_off = 1'b1;
    hold_asked <= hold_asked + 1;
    repeat (12) translate($urandom);
    gaps_off = 1'b0;
  endtask

  // Random traffic in phases, each with its own paging setting and hot slots.
  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      set_paging(PHASE_PAGING[p]);
      foreach (hot_slot[i]) hot_slot[i] = DIR_AW'($urandom);
      repeat (105) offer_request(random_request());
    end
  endtask

  // Long receiver hold-off, counted down here on request.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_asked;
    end
  end

  // Receiver stall pattern that switches between randomly chosen styles.
  always @(posedge clk_i) begin
    if (rx_style_left == 0) begin
      rx_style      = rx_style_e'($urandom_range(0, 3));
      rx_style_left = $urandom_range(32, 256);
    end else begin
      rx_style_left = rx_style_left - 1;
    end
    rx_phase = rx_phase + 1;
    case (rx_style)
      RX_STEADY: rx_pick = 1'b1;
      RX_COIN:   rx_pick = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_pick = ($urandom_range(0, 3) == 0);
      default:   rx_pick = (rx_phase % 3 != 0);
    endcase
    m_axis_tready <= rx_pick && (hold_left == 0);
  end

  // Compares each result transaction with the oldest expected one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        flag_error("result arrived with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        got.phys_address   = m_axis_tdata[31:0];
        got.fault          = m_axis_tdata[32];
        got.mapped_count   = m_axis_tdata[43:33];
        got.skipped_count  = m_axis_tdata[54:44];
        got.pool_exhausted = m_axis_tdata[55];
        if (got.phys_address !== want.phys_address)
          flag_error($sformatf("phys_address %h, expected %h",
                               got.phys_address, want.phys_address));
        if (got.fault !== want.fault)
          flag_error($sformatf("fault %b, expected %b", got.fault, want.fault));
        if (got.mapped_count !== want.mapped_count)
          flag_error($sformatf("mapped_count %0d, expected %0d",
                               got.mapped_count, want.mapped_count));
        if (got.skipped_count !== want.skipped_count)
          flag_error($sformatf("skipped_count %0d, expected %0d",
                               got.skipped_count, want.skipped_count));
        if (got.pool_exhausted !== want.pool_exhausted)
          flag_error($sformatf("pool_exhausted %b, expected %b",
                               got.pool_exhausted, want.pool_exhausted));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset, the tests in turn, then the verdict.
  initial begin
    foreach (dir_present[k]) begin
      dir_present[k]    = 1'b0;
      dir_slot_table[k] = '0;
    end
    foreach (pool_mem[k]) pool_mem[k] = '0;
    foreach (hot_slot[k]) hot_slot[k] = '0;
    tables_taken = 0;
    paging_on    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_paging_off();
    test_translate_walk();
    test_map_runs();
    test_clear_directory();
    test_pool_exhaustion();
    test_backpressure();
    test_random_traffic();

    settle_engine();
    repeat (24) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
